[hw/rtl/nhcp_pkg.sv]
// ----------------------------------------------------------------------------
// nhcp_pkg
// Shared types, character codes and field rules of the heading-control
// sentence parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nhcp_pkg;

   localparam int VALUE_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_V     = 8'h56;

   // Positions inside the address field.
   localparam logic [3:0] ADDR_POS_H    = 4'd3;
   localparam logic [3:0] ADDR_POS_T    = 4'd4;
   localparam logic [3:0] ADDR_POS_KIND = 4'd5;
   localparam logic [3:0] ADDR_LEN      = 4'd6;
   localparam logic [3:0] CHAR_COUNT_MAX = 4'd15;
   localparam logic [1:0] DOT_COUNT_MAX  = 2'd3;

   localparam logic [4:0] FLD_ADDR            = 5'd1;
   localparam logic [4:0] FLD_OVERRIDE        = 5'd2;
   localparam logic [4:0] FLD_RUDDER_DIR      = 5'd4;
   localparam logic [4:0] FLD_STEER_MODE      = 5'd5;
   localparam logic [4:0] FLD_TURN_MODE       = 5'd6;
   localparam logic [4:0] FLD_HEADING_REF     = 5'd14;
   localparam logic [4:0] FLD_TAIL            = 5'd15;
   localparam logic [4:0] FLD_RUDDER_STAT     = 5'd16;
   localparam logic [4:0] FLD_OFF_HEADING_STAT = 5'd17;
   localparam logic [4:0] LAST_HTC            = 5'd15;
   localparam logic [4:0] LAST_HTD            = 5'd18;

   localparam logic KIND_HTC = 1'b0;
   localparam logic KIND_HTD = 1'b1;

   // Everything of a queued result except its value.
   typedef struct packed {
      logic       kind;
      logic [4:0] num;
      logic       failed;
      logic       done;
      logic       second;   // a failed, final report of the next field follows
   } nhcp_tag_type;

   function automatic logic is_letter_field(input logic [4:0] fi);
      logic res;
      begin
         case (fi)
            FLD_OVERRIDE, FLD_RUDDER_DIR, FLD_STEER_MODE, FLD_TURN_MODE,
            FLD_HEADING_REF, FLD_TAIL, FLD_RUDDER_STAT,
            FLD_OFF_HEADING_STAT: res = 1'b1;
            default: res = 1'b0;
         endcase
         return res;
      end
   endfunction

   function automatic logic letter_ok(input logic [4:0] fi, input logic kind,
                                      input logic [7:0] ch);
      logic av;
      logic tm;
      logic res;
      begin
         av = (ch == CH_A) || (ch == CH_V);
         tm = (ch == CH_T) || (ch == CH_M);
         case (fi)
            FLD_OVERRIDE:    res = av;
            FLD_RUDDER_DIR:  res = (ch == CH_L) || (ch == CH_R);
            FLD_STEER_MODE:  res = (ch == CH_M) || (ch == CH_S) || (ch == CH_H) ||
                                   (ch == CH_R) || (ch == CH_T);
            FLD_TURN_MODE:   res = (ch == CH_R) || (ch == CH_T) || (ch == CH_N);
            FLD_HEADING_REF: res = tm;
            FLD_TAIL:        res = (kind == KIND_HTD) ? av : tm;
            FLD_RUDDER_STAT, FLD_OFF_HEADING_STAT: res = av;
            default:         res = 1'b0;
         endcase
         return res;
      end
   endfunction

   function automatic logic field_pass(input logic [4:0] fi, input logic [3:0] cc,
                                       input logic bad, input logic digit,
                                       input logic [7:0] held, input logic kind);
      logic res;
      begin
         if (bad) begin
            res = 1'b0;
         end else if (fi == FLD_ADDR) begin
            res = (cc == ADDR_LEN);
         end else if (is_letter_field(fi)) begin
            res = (cc == 4'd1) && letter_ok(fi, kind, held);
         end else begin
            res = digit;
         end
         return res;
      end
   endfunction

endpackage

`default_nettype wire

[hw/rtl/nmea_heading_control_parser.sv]
// ----------------------------------------------------------------------------
// nmea_heading_control_parser
// Checks HTC and HTD heading-control sentences one byte per beat and
// reports every closed field, ending the run at the first failing field.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                          tuser / tlast
//  req_     in         [7:0] char_in                  tuser starts_sentence,
//                                                     tlast ends_sentence
//  rsp_     out        [4:0] field_number,            tuser {failed,
//                      [VALUE_BITS+4:5] field_value   sentence_kind}, tlast run_done
//
//  A byte is taken every cycle while the event queue has room; the field
//  tracker updates its state in that same cycle.
//  Each byte makes zero, one or two results; a two-result byte holds the
//  output stage for both of its results, so the queue absorbs the burst.
//  A stalled rsp_ side fills the QUEUE_DEPTH-entry queue and then lowers
//  req_tready.
//  Synchronous reset leaves the tracker waiting for a start mark.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_heading_control_parser import nhcp_pkg::*; #(
   parameter int  VALUE_BITS    = VALUE_BITS_DEFAULT,
   parameter int  QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT,
   localparam int RSP_DATA_BITS = ((5 + VALUE_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] char_in
   input  wire logic                 req_tuser,   // [0] starts_sentence
   input  wire logic                 req_tlast,   // ends_sentence
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // [4:0] field_number, then field_value, zero pad
   output logic [1:0]                rsp_tuser,   // [0] sentence_kind, [1] failed
   output logic                      rsp_tlast    // run_done
);

   localparam int TAG_BITS      = $bits(nhcp_tag_type);
   localparam int ENTRY_BITS    = VALUE_BITS + TAG_BITS;

   logic                  accept;
   logic                  push, q_full, q_not_empty, q_pop;
   nhcp_tag_type          push_tag, q_tag;
   logic [VALUE_BITS-1:0] push_value, q_value;
   logic [ENTRY_BITS-1:0] q_head;
   logic                  out_kind, out_failed, out_done;
   logic [4:0]            out_num;
   logic [VALUE_BITS-1:0] out_value;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   nhcp_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .char_in         (req_tdata),
      .starts_sentence (req_tuser),
      .ends_sentence   (req_tlast),
      .push            (push),
      .push_tag        (push_tag),
      .push_value      (push_value)
   );

   nhcp_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push && accept),
      .push_data ({push_value, push_tag}),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   assign q_tag   = q_head[TAG_BITS-1:0];
   assign q_value = q_head[ENTRY_BITS-1:TAG_BITS];

   nhcp_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_tag       (q_tag),
      .q_value     (q_value),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (out_kind),
      .out_num     (out_num),
      .out_value   (out_value),
      .out_failed  (out_failed),
      .out_done    (out_done)
   );

   assign rsp_tdata = RSP_DATA_BITS'({out_value, out_num});
   assign rsp_tuser = {out_failed, out_kind};
   assign rsp_tlast = out_done;

endmodule

`default_nettype wire

[hw/rtl/nhcp_front.sv]
// ----------------------------------------------------------------------------
// nhcp_front
// Field tracker: absorbs one sentence byte per accepted beat, closes fields
// and pushes one result event (one or two results) into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nhcp_front import nhcp_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            char_in,
   input  wire logic                  starts_sentence,
   input  wire logic                  ends_sentence,
   output logic                       push,
   output nhcp_tag_type               push_tag,
   output logic [VALUE_BITS-1:0]      push_value
);

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   logic [4:0]            field_index_ff, field_index_in, fi_s;
   logic [3:0]            char_count_ff, char_count_in, cc_s;
   logic [VALUE_BITS-1:0] accum_ff, accum_in, acc_s;
   logic [1:0]            dot_count_ff, dot_count_in, dot_s;
   logic                  digit_seen_ff, digit_seen_in, dig_s;
   logic                  field_bad_ff, field_bad_in, bad_s;
   logic [7:0]            held_ff, held_in, held_s;
   logic                  kind_ff, kind_in, kind_s;
   logic                  idle_ff, idle_in, idle_s;

   logic                  is_last, delim, pass_now, pass_end, last_end, is_digit;
   logic [VALUE_BITS-1:0] val_now, val_end;
   logic [VALUE_BITS+3:0] acc_next;

   always_comb begin
      // A start mark drops the old run before the byte is looked at.
      fi_s   = starts_sentence ? FLD_ADDR : field_index_ff;
      cc_s   = starts_sentence ? 4'd0 : char_count_ff;
      acc_s  = starts_sentence ? '0 : accum_ff;
      dot_s  = starts_sentence ? 2'd0 : dot_count_ff;
      dig_s  = starts_sentence ? 1'b0 : digit_seen_ff;
      bad_s  = starts_sentence ? 1'b0 : field_bad_ff;
      held_s = starts_sentence ? 8'd0 : held_ff;
      kind_s = starts_sentence ? KIND_HTC : kind_ff;
      idle_s = starts_sentence ? 1'b0 : idle_ff;

      field_index_in = fi_s;
      char_count_in  = cc_s;
      accum_in       = acc_s;
      dot_count_in   = dot_s;
      digit_seen_in  = dig_s;
      field_bad_in   = bad_s;
      held_in        = held_s;
      kind_in        = kind_s;
      idle_in        = idle_s;

      push       = 1'b0;
      push_tag   = '0;
      push_value = '0;

      is_last  = (fi_s == ((kind_s == KIND_HTD) ? LAST_HTD : LAST_HTC));
      delim    = (char_in == (is_last ? CH_STAR : CH_COMMA));
      pass_now = field_pass(fi_s, cc_s, bad_s, dig_s, held_s, kind_s);
      val_now  = (fi_s == FLD_ADDR || is_letter_field(fi_s)) ?
                 VALUE_BITS'(held_s) : acc_s;
      is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
      acc_next = ({4'd0, acc_s} << 3) + ({4'd0, acc_s} << 1)
                 + (VALUE_BITS+4)'(char_in - CH_ZERO);
      pass_end = 1'b0;
      last_end = 1'b0;
      val_end  = '0;

      if (!idle_s) begin
         if (delim) begin
            push          = 1'b1;
            push_tag.kind = kind_s;
            push_tag.num  = fi_s;
            if (!pass_now || is_last) begin
               push_tag.failed = !pass_now;
               push_tag.done   = 1'b1;
               push_value      = pass_now ? val_now : '0;
               idle_in         = 1'b1;
            end else begin
               push_value      = val_now;
               field_index_in  = fi_s + 5'd1;
               char_count_in   = 4'd0;
               accum_in        = '0;
               dot_count_in    = 2'd0;
               digit_seen_in   = 1'b0;
               field_bad_in    = 1'b0;
               held_in         = 8'd0;
               // Ending right after a delimiter leaves the next field empty.
               push_tag.second = ends_sentence;
               idle_in         = ends_sentence;
            end
         end else begin
            if (fi_s == FLD_ADDR) begin
               if (cc_s == ADDR_POS_H && char_in != CH_H) field_bad_in = 1'b1;
               if (cc_s == ADDR_POS_T && char_in != CH_T) field_bad_in = 1'b1;
               if (cc_s == ADDR_POS_KIND) begin
                  held_in = char_in;
                  if (char_in == CH_C) begin
                     kind_in = KIND_HTC;
                  end else if (char_in == CH_D) begin
                     kind_in = KIND_HTD;
                  end else begin
                     field_bad_in = 1'b1;
                  end
               end
            end else if (is_letter_field(fi_s)) begin
               if (cc_s == 4'd0) held_in = char_in;
            end else if (is_digit) begin
               if (dot_s == 2'd0) begin
                  accum_in = (acc_next > (VALUE_BITS+4)'(VALUE_MAX)) ?
                             VALUE_MAX : acc_next[VALUE_BITS-1:0];
               end
               if (dot_s < 2'd2) digit_seen_in = 1'b1;
            end else if (char_in == CH_DOT) begin
               if (dot_s < DOT_COUNT_MAX) dot_count_in = dot_s + 2'd1;
            end else begin
               field_bad_in = 1'b1;
            end
            if (cc_s < CHAR_COUNT_MAX) char_count_in = cc_s + 4'd1;

            if (ends_sentence) begin
               // The open field is closed as if a delimiter had come.
               pass_end = field_pass(fi_s, char_count_in, field_bad_in,
                                     digit_seen_in, held_in, kind_in);
               last_end = (fi_s == ((kind_in == KIND_HTD) ? LAST_HTD : LAST_HTC));
               val_end  = (fi_s == FLD_ADDR || is_letter_field(fi_s)) ?
                          VALUE_BITS'(held_in) : accum_in;
               push          = 1'b1;
               push_tag.kind = kind_in;
               push_tag.num  = fi_s;
               idle_in       = 1'b1;
               if (char_count_in == 4'd0 || !pass_end) begin
                  push_tag.failed = 1'b1;
                  push_tag.done   = 1'b1;
               end else if (last_end) begin
                  push_tag.done = 1'b1;
                  push_value    = val_end;
               end else begin
                  push_tag.second = 1'b1;
                  push_value      = val_end;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= 5'd0;
         char_count_ff  <= 4'd0;
         accum_ff       <= '0;
         dot_count_ff   <= 2'd0;
         digit_seen_ff  <= 1'b0;
         field_bad_ff   <= 1'b0;
         held_ff        <= 8'd0;
         kind_ff        <= KIND_HTC;
         idle_ff        <= 1'b1;
      end else if (accept) begin
         field_index_ff <= field_index_in;
         char_count_ff  <= char_count_in;
         accum_ff       <= accum_in;
         dot_count_ff   <= dot_count_in;
         digit_seen_ff  <= digit_seen_in;
         field_bad_ff   <= field_bad_in;
         held_ff        <= held_in;
         kind_ff        <= kind_in;
         idle_ff        <= idle_in;
      end
   end

   // The second report only ever follows a field that passed and was not last.
   assert property (@(posedge clock) disable iff (reset)
      (push && push_tag.second) |-> (!push_tag.failed && !push_tag.done))
      else $error("second report attached to a closing result");

   // A final result always leaves the tracker waiting for the next start.
   assert property (@(posedge clock) disable iff (reset)
      (accept && push && push_tag.done) |=> idle_ff)
      else $error("run not ended after its final result");

endmodule

`default_nettype wire

[hw/rtl/nhcp_queue.sv]
// ----------------------------------------------------------------------------
// nhcp_queue
// Small first-in first-out buffer of result events between the field
// tracker and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module nhcp_queue import nhcp_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [PTR_BITS-1:0] PTR_ONE  = PTR_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CNT_FULL);
      not_empty = (count_ff != '0);
      head_data = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_FULL) && !(push && full && !pop) && !(pop && !not_empty))
      else $error("queue overflow or underflow");

endmodule

`default_nettype wire

[hw/rtl/nhcp_back.sv]
// ----------------------------------------------------------------------------
// nhcp_back
// Output sequencer: takes result events from the queue and delivers them
// one result per beat through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nhcp_back import nhcp_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_not_empty,
   input  wire nhcp_tag_type          q_tag,
   input  wire logic [VALUE_BITS-1:0] q_value,
   output logic                       q_pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic                       out_kind,
   output logic [4:0]                 out_num,
   output logic [VALUE_BITS-1:0]      out_value,
   output logic                       out_failed,
   output logic                       out_done
);

   logic                  valid_ff, valid_in;
   logic                  second_ff, second_in;
   logic                  kind_ff, kind_in;
   logic [4:0]            num_ff, num_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  failed_ff, failed_in;
   logic                  done_ff, done_in;
   logic                  load;

   always_comb begin
      load      = !valid_ff || out_ready;
      q_pop     = 1'b0;
      valid_in  = valid_ff;
      second_in = second_ff;
      kind_in   = kind_ff;
      num_in    = num_ff;
      value_in  = value_ff;
      failed_in = failed_ff;
      done_in   = done_ff;
      if (load) begin
         if (second_ff) begin
            // The follow-up report names the field after the one just shown.
            valid_in  = 1'b1;
            second_in = 1'b0;
            num_in    = num_ff + 5'd1;
            value_in  = '0;
            failed_in = 1'b1;
            done_in   = 1'b1;
         end else if (q_not_empty) begin
            q_pop     = 1'b1;
            valid_in  = 1'b1;
            second_in = q_tag.second;
            kind_in   = q_tag.kind;
            num_in    = q_tag.num;
            value_in  = q_value;
            failed_in = q_tag.failed;
            done_in   = q_tag.done;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      num_ff    <= num_in;
      value_ff  <= value_in;
      failed_ff <= failed_in;
      done_ff   <= done_in;
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_num    = num_ff;
   assign out_value  = value_ff;
   assign out_failed = failed_ff;
   assign out_done   = done_ff;

   assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (valid_ff && !done_ff && !failed_ff))
      else $error("pending follow-up without a passing first report");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives byte streams of HTC and HTD heading-control sentences into the
// parser and compares every reported field with a cycle-free field tracker.
// Well-formed sentences with random content make up most of the traffic.
// Damaged addresses, bad letters, bad numbers, truncations, missing end
// marks and stray bytes make up the rest. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nhcp_pkg::*;

   localparam int VAL_BITS    = VALUE_BITS_DEFAULT;
   localparam int RSP_BITS    = ((5 + VAL_BITS + 7) / 8) * 8;
   localparam int BYTE_TARGET = 1350;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      bit          kind;
      bit [4:0]    num;
      bit [15:0]   value;
      bit          failed;
      bit          done;
   } field_report_type;

   // Tracks the sentence the way the parser should and keeps the reports
   // that are still owed by the block, oldest first.
   class field_report_board;
      bit [4:0]          fld;
      bit [3:0]          nchars;
      bit [15:0]         accum;
      bit [1:0]          ndots;
      bit                saw_digit;
      bit                broken;
      bit [7:0]          letter;
      bit                htd;
      bit                waiting;
      field_report_type  due_reports[$];
      int                mismatches;

      function new();
         clear_field();
         fld = 5'd0;
         htd = KIND_HTC;
         waiting = 1'b1;
         mismatches = 0;
      endfunction

      // Letters a flag field accepts; an empty string marks a number field.
      static function string letter_set(bit [4:0] f, bit is_htd);
         case (f)
            FLD_OVERRIDE:                          return "AV";
            FLD_RUDDER_DIR:                        return "LR";
            FLD_STEER_MODE:                        return "MSHRT";
            FLD_TURN_MODE:                         return "RTN";
            FLD_HEADING_REF:                       return "TM";
            FLD_TAIL:                              return is_htd ? "AV" : "TM";
            FLD_RUDDER_STAT, FLD_OFF_HEADING_STAT: return "AV";
            default:                               return "";
         endcase
      endfunction

      function void clear_field();
         nchars = 4'd0;
         accum = 16'd0;
         ndots = 2'd0;
         saw_digit = 1'b0;
         broken = 1'b0;
         letter = 8'd0;
      endfunction

      function bit [4:0] final_field();
         return htd ? LAST_HTD : LAST_HTC;
      endfunction

      function bit closes_ok(output bit [15:0] v);
         string set;
         v = 16'd0;
         if (broken) return 1'b0;
         if (fld == FLD_ADDR) begin
            v = 16'(letter);
            return nchars == ADDR_LEN;
         end
         set = letter_set(fld, htd);
         if (set.len() == 0) begin
            v = accum;
            return saw_digit;
         end
         if (nchars != 4'd1) return 1'b0;
         for (int i = 0; i < set.len(); i++) begin
            if (set[i] == letter) begin
               v = 16'(letter);
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void take_char(bit [7:0] c);
         int unsigned grown;
         string       set;
         set = letter_set(fld, htd);
         if (fld == FLD_ADDR) begin
            if (nchars == ADDR_POS_H && c != CH_H) broken = 1'b1;
            if (nchars == ADDR_POS_T && c != CH_T) broken = 1'b1;
            if (nchars == ADDR_POS_KIND) begin
               letter = c;
               if (c == CH_C) htd = KIND_HTC;
               else if (c == CH_D) htd = KIND_HTD;
               else broken = 1'b1;
            end
         end else if (set.len() != 0) begin
            if (nchars == 4'd0) letter = c;
         end else if (c >= CH_ZERO && c <= CH_NINE) begin
            // Only the integer part counts, and it sticks at the top value.
            if (ndots == 2'd0) begin
               grown = 32'(accum) * 32'd10 + 32'(c - CH_ZERO);
               accum = (grown > 32'hFFFF) ? 16'hFFFF : grown[15:0];
            end
            if (ndots < 2'd2) saw_digit = 1'b1;
         end else if (c == CH_DOT) begin
            if (ndots != DOT_COUNT_MAX) ndots++;
         end else begin
            broken = 1'b1;
         end
         if (nchars != CHAR_COUNT_MAX) nchars++;
      endfunction

      function void report(bit [4:0] num, bit [15:0] v, bit bad, bit done);
         field_report_type r;
         r.kind = htd;
         r.num = num;
         r.value = bad ? 16'd0 : v;
         r.failed = bad;
         r.done = done;
         due_reports.push_back(r);
      endfunction

      function void note_byte(bit [7:0] c, bit first, bit last);
         bit [15:0] v;
         bit [7:0]  delim;
         if (first) begin
            clear_field();
            fld = FLD_ADDR;
            htd = KIND_HTC;
            waiting = 1'b0;
         end
         if (waiting) return;
         delim = (fld == final_field()) ? CH_STAR : CH_COMMA;
         if (c == delim) begin
            if (!closes_ok(v)) begin
               report(fld, 16'd0, 1'b1, 1'b1);
               waiting = 1'b1;
            end else if (fld == final_field()) begin
               report(fld, v, 1'b0, 1'b1);
               waiting = 1'b1;
            end else begin
               report(fld, v, 1'b0, 1'b0);
               fld++;
               clear_field();
            end
         end else begin
            take_char(c);
         end
         // An end mark closes the open field; a passing field that is not the
         // last one is followed by a failed report of the field after it.
         if (last && !waiting) begin
            if (nchars == 4'd0 || !closes_ok(v)) begin
               report(fld, 16'd0, 1'b1, 1'b1);
            end else if (fld == final_field()) begin
               report(fld, v, 1'b0, 1'b1);
            end else begin
               report(fld, v, 1'b0, 1'b0);
               report(fld + 5'd1, 16'd0, 1'b1, 1'b1);
            end
            waiting = 1'b1;
         end
      endfunction

      function void compare(string what, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         end
      endfunction

      function void check_report(bit kind, bit [4:0] num, bit [15:0] value,
                                 bit failed, bit done);
         field_report_type want;
         if (due_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got field %0d value %0d",
                     $time, num, value);
            return;
         end
         want = due_reports.pop_front();
         compare("sentence_kind", want.kind, kind);
         compare("field_number", want.num, num);
         compare("field_value", want.value, value);
         compare("failed", want.failed, failed);
         compare("run_done", want.done, done);
      endfunction

      function int pending();
         return due_reports.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'd0;
   logic                 req_tuser = 1'b0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]  rsp_tdata;   // [4:0] field_number, [20:5] field_value, zero pad
   logic [1:0]           rsp_tuser;   // [0] sentence_kind, [1] failed
   logic                 rsp_tlast;   // run_done

   int                   cycle_count = 0;
   int                   bytes_sent = 0;
   bit [7:0]             line_q[$];
   field_report_board    field_board = new();

   nmea_heading_control_parser #(
      .VALUE_BITS(VAL_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("nmea_heading_control_parser test failed");
         $finish;
      end
   end

   // Stretches in which neither side idles.
   function automatic bit quiet_phase();
      return (cycle_count / 1500) % 4 == 1;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic bit [7:0] any_upper();
      return CH_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic bit [7:0] any_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endfunction

   function automatic void put_address(bit is_htd);
      put_text("$");
      line_q.push_back(any_upper());
      line_q.push_back(any_upper());
      put_text("HT");
      line_q.push_back(is_htd ? CH_D : CH_C);
      if ($urandom_range(0, 15) == 0) begin
         case ($urandom_range(0, 4))
            0: line_q[ADDR_POS_H] = any_upper();
            1: line_q[ADDR_POS_T] = any_upper();
            2: line_q[ADDR_POS_KIND] = any_upper();
            3: line_q.delete(2);
            default: line_q.push_back(any_upper());
         endcase
      end
   endfunction

   function automatic void put_letter(bit [4:0] f, bit is_htd);
      string set;
      int    r;
      set = field_report_board::letter_set(f, is_htd);
      r = $urandom_range(0, 99);
      if (r < 90) begin
         line_q.push_back(set[$urandom_range(0, set.len() - 1)]);
      end else if (r < 94) begin
         line_q.push_back(any_upper());
      end else if (r >= 97) begin
         line_q.push_back(set[$urandom_range(0, set.len() - 1)]);
         line_q.push_back(set[$urandom_range(0, set.len() - 1)]);
      end
   endfunction

   function automatic void put_number();
      string junk;
      int    n;
      junk = "A*/ -";
      case ($urandom_range(0, 9))
         0: begin
            n = $urandom_range(6, 9);
            repeat (n) line_q.push_back(any_digit());
         end
         1: begin
            put_text(".");
            line_q.push_back(any_digit());
         end
         2: begin
            line_q.push_back(any_digit());
            put_text(".");
         end
         3: begin
            line_q.push_back(any_digit());
            put_text(".");
            line_q.push_back(any_digit());
            put_text(".");
            line_q.push_back(any_digit());
         end
         4: begin
            put_text("..");
            line_q.push_back(any_digit());
         end
         5: ;
         6: begin
            line_q.push_back(any_digit());
            line_q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
            line_q.push_back(any_digit());
         end
         default: begin
            n = $urandom_range(1, 5);
            repeat (n) line_q.push_back(any_digit());
            if ($urandom_range(0, 1)) begin
               put_text(".");
               n = $urandom_range(0, 2);
               repeat (n) line_q.push_back(any_digit());
            end
         end
      endcase
   endfunction

   function automatic void build_sentence(output bit with_end);
      string    hex_chars;
      string    fset;
      bit       is_htd;
      bit [4:0] last_f;
      int       cut;
      hex_chars = "0123456789ABCDEF";
      is_htd = 1'($urandom_range(0, 1));
      last_f = is_htd ? LAST_HTD : LAST_HTC;
      line_q.delete();
      put_address(is_htd);
      for (int f = 2; f <= last_f; f++) begin
         line_q.push_back(CH_COMMA);
         fset = field_report_board::letter_set(5'(f), is_htd);
         if (fset.len() != 0)
            put_letter(5'(f), is_htd);
         else
            put_number();
      end
      line_q.push_back(CH_STAR);
      line_q.push_back(hex_chars[$urandom_range(0, 15)]);
      line_q.push_back(hex_chars[$urandom_range(0, 15)]);
      if ($urandom_range(0, 1)) begin
         line_q.push_back(8'h0D);
         line_q.push_back(8'h0A);
      end
      with_end = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(0, line_q.size() - 1);
         line_q = line_q[0:cut];
      end
   endfunction

   task automatic send_byte(input bit [7:0] c, input bit first, input bit last);
      int gap;
      gap = quiet_phase() ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= first;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      field_board.note_byte(c, first, last);
   endtask

   task automatic send_line(input bit with_end);
      int n;
      n = line_q.size();
      for (int i = 0; i < n; i++)
         send_byte(line_q[i], i == 0, with_end && (i == n - 1));
      bytes_sent += n;
      line_q.delete();
   endtask

   initial begin
      int stall_left;
      int beats_taken;
      bit long_hold_done;
      stall_left = 0;
      beats_taken = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            field_board.check_report(rsp_tuser[0], rsp_tdata[4:0],
                                     rsp_tdata[VAL_BITS+4:5], rsp_tuser[1], rsp_tlast);
            beats_taken++;
         end
         // One long hold-off lets the result queue fill and stall the input.
         if (!long_hold_done && beats_taken >= 120) begin
            long_hold_done = 1'b1;
            stall_left = 300;
         end else if (stall_left == 0 && !quiet_phase()) begin
            stall_left = idle_len();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      bit with_end;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes outside a sentence are dropped.
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(CH_A, 1'b0, 1'b0);
      put_text("$GPHTC,A,65535,R,T,N,0,99999,1.,.5,12.3.4,0,7,M,T*4F");
      line_q.push_back(8'h0D);
      line_q.push_back(8'h0A);
      send_line(1'b1);
      put_text("$IIHTD,V,0,L,S,T,1,65536,3,4,5,6,7,T,A,V,A,359.9*00");
      send_line(1'b1);
      // Left open; the next start drops it.
      put_text("$GPHTC,V,1");
      send_line(1'b0);
      put_text("$GPHTD,A,12");
      send_line(1'b1);
      put_text("$GPHTC,V,");
      send_line(1'b1);
      put_text("$GPXTC,A,B*");
      send_line(1'b1);
      put_text("$GPHTCX,A");
      send_line(1'b1);
      put_text("$GPHTC,X,");
      send_line(1'b1);
      put_text("$GPHTC,A,1*2,");
      send_line(1'b1);
      put_text("$GPHTC,A,..5,");
      send_line(1'b1);
      put_text("$GPHTC,V,1,L,H,R,1,2,3,4,5,6,7,T,T,M*");
      send_line(1'b1);
      put_text("$GPHTC,V,1,L,M,R,1,2,3,4,5,6,7,T,M");
      send_line(1'b1);

      while (bytes_sent < BYTE_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0,
                                 1'($urandom_range(0, 1)));
         end
         build_sentence(with_end);
         send_line(with_end);
      end
      req_tvalid <= 1'b0;

      while (field_board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (field_board.mismatches == 0)
         $display("nmea_heading_control_parser test passed");
      else
         $display("nmea_heading_control_parser test failed");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/nhcp_pkg.sv
hw/rtl/nhcp_front.sv
hw/rtl/nhcp_queue.sv
hw/rtl/nhcp_back.sv
hw/rtl/nmea_heading_control_parser.sv
verif/tb_top.sv
